// ===== hdl/edd_pkg.sv =====
// Shared types, constants and kernel tables of the error-diffusion dither core.
package edd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int ROW_SLOTS  = 3;
  localparam int FRAC_BITS  = 16;
  localparam int FRAC_UP    = FRAC_BITS - 12;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W     = $clog2(ROW_SLOTS);
  localparam int ADDR_W     = COL_W + SLOT_W;
  localparam int MEM_DEPTH  = ROW_SLOTS * MAX_WIDTH;
  localparam int ERR_W      = 20;
  localparam int TAP_IDX_W  = 4;
  localparam int NUM_TAPS   = 61;
  localparam int M_W        = 32;   // residual times strength
  localparam int N_W        = 35;   // times tap weight
  localparam int Q1_W       = 19;
  localparam int U_W        = 23;
  localparam int P_W        = 46;
  localparam int R_W        = 26;
  localparam int RECIP_SH   = 24;
  localparam int BIAS_SH    = 18;

  typedef enum logic [2:0] {
    REG_KERNEL   = 3'd0,
    REG_SERP     = 3'd1,
    REG_BITS     = 3'd2,
    REG_STRENGTH = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    DIV_1  = 2'd0,
    DIV_3  = 2'd1,
    DIV_21 = 2'd2
  } div_e;

  typedef struct packed {
    logic [2:0]  kernel;
    logic        serp;
    logic [3:0]  bits;
    logic [15:0] strength;
    logic [11:0] width;
    logic [11:0] height;
  } cfg_t;

  typedef struct packed {
    logic                 load;
    logic                 rd_cur;
    logic                 sum;
    logic                 mul_str;
    logic                 tap_a;
    logic                 tap_b;
    logic                 tap_c;
    logic                 tap_d;
    logic                 wr_tap;
    logic                 push;
    logic                 clr_we;
    logic                 clr_all;
    logic [ADDR_W-1:0]    clr_cnt;
    logic [TAP_IDX_W-1:0] tap_idx;
  } cmd_t;

  typedef struct packed {
    logic tap_ok;
    logic tap_last;
    logic out_free;
    logic row_end;
    logic frame_end;
  } sts_t;

  typedef struct packed {
    logic signed [2:0] dx;
    logic [1:0]        dy;
    logic [3:0]        num;
  } tap_t;

  localparam tap_t TAP_TABLE [NUM_TAPS] = '{
    // Floyd-Steinberg
    '{3'sd1,2'd0,4'd7}, '{-3'sd1,2'd1,4'd3}, '{3'sd0,2'd1,4'd5}, '{3'sd1,2'd1,4'd1},
    // Jarvis-Judice-Ninke
    '{3'sd1,2'd0,4'd7}, '{3'sd2,2'd0,4'd5}, '{-3'sd2,2'd1,4'd3}, '{-3'sd1,2'd1,4'd5},
    '{3'sd0,2'd1,4'd7}, '{3'sd1,2'd1,4'd5}, '{3'sd2,2'd1,4'd3},
    '{-3'sd2,2'd2,4'd1}, '{-3'sd1,2'd2,4'd3}, '{3'sd0,2'd2,4'd5}, '{3'sd1,2'd2,4'd3},
    '{3'sd2,2'd2,4'd1},
    // Stucki
    '{3'sd1,2'd0,4'd8}, '{3'sd2,2'd0,4'd4}, '{-3'sd2,2'd1,4'd2}, '{-3'sd1,2'd1,4'd4},
    '{3'sd0,2'd1,4'd8}, '{3'sd1,2'd1,4'd4}, '{3'sd2,2'd1,4'd2},
    '{-3'sd2,2'd2,4'd1}, '{-3'sd1,2'd2,4'd2}, '{3'sd0,2'd2,4'd4}, '{3'sd1,2'd2,4'd2},
    '{3'sd2,2'd2,4'd1},
    // Atkinson
    '{3'sd1,2'd0,4'd1}, '{3'sd2,2'd0,4'd1}, '{-3'sd1,2'd1,4'd1}, '{3'sd0,2'd1,4'd1},
    '{3'sd1,2'd1,4'd1}, '{3'sd0,2'd2,4'd1},
    // Burkes
    '{3'sd1,2'd0,4'd8}, '{3'sd2,2'd0,4'd4}, '{-3'sd2,2'd1,4'd2}, '{-3'sd1,2'd1,4'd4},
    '{3'sd0,2'd1,4'd8}, '{3'sd1,2'd1,4'd4}, '{3'sd2,2'd1,4'd2},
    // Sierra
    '{3'sd1,2'd0,4'd5}, '{3'sd2,2'd0,4'd3}, '{-3'sd2,2'd1,4'd2}, '{-3'sd1,2'd1,4'd4},
    '{3'sd0,2'd1,4'd5}, '{3'sd1,2'd1,4'd4}, '{3'sd2,2'd1,4'd2},
    '{-3'sd1,2'd2,4'd2}, '{3'sd0,2'd2,4'd3}, '{3'sd1,2'd2,4'd2},
    // Sierra two-row
    '{3'sd1,2'd0,4'd4}, '{3'sd2,2'd0,4'd3}, '{-3'sd2,2'd1,4'd1}, '{-3'sd1,2'd1,4'd2},
    '{3'sd0,2'd1,4'd3}, '{3'sd1,2'd1,4'd2}, '{3'sd2,2'd1,4'd1},
    // Sierra Lite
    '{3'sd1,2'd0,4'd2}, '{-3'sd1,2'd1,4'd1}, '{3'sd0,2'd1,4'd1}
  };

  localparam logic [5:0] KERN_FIRST [8] = '{6'd0, 6'd4, 6'd16, 6'd28,
                                            6'd34, 6'd41, 6'd51, 6'd58};
  localparam logic [TAP_IDX_W-1:0] KERN_COUNT [8] = '{4'd4, 4'd12, 4'd12, 4'd6,
                                                      4'd7, 4'd10, 4'd7, 4'd3};
  // Denominator 32768*den split as c * 2^shift
  localparam logic [4:0] KERN_SHIFT [8] = '{5'd19, 5'd19, 5'd16, 5'd18,
                                            5'd20, 5'd20, 5'd19, 5'd17};
  localparam div_e KERN_DIV [8] = '{DIV_1, DIV_3, DIV_21, DIV_1,
                                    DIV_1, DIV_1, DIV_1, DIV_1};

  function automatic logic [4:0] div_const(div_e d);
    logic [4:0] c;
    unique case (d)
      DIV_3:   c = 5'd3;
      DIV_21:  c = 5'd21;
      default: c = 5'd1;
    endcase
    return c;
  endfunction

  // Reciprocal floor(2^24/c)+1, exact floor with one correction for u < 2^24
  function automatic logic [U_W-1:0] div_recip(div_e d);
    logic [U_W-1:0] m;
    unique case (d)
      DIV_3:   m = 23'd5592406;
      DIV_21:  m = 23'd798916;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/edd_regs.sv =====
// Configuration register bank behind the APB-style port.
module edd_regs import edd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel   <= 3'd0;
      cfg_q.serp     <= 1'b0;
      cfg_q.bits     <= 4'd8;
      cfg_q.strength <= 16'd32768;
      cfg_q.width    <= 12'd640;
      cfg_q.height   <= 12'd480;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_KERNEL:   cfg_q.kernel   <= pwdata[2:0];
        REG_SERP:     cfg_q.serp     <= pwdata[0];
        REG_BITS:     cfg_q.bits     <= pwdata[3:0];
        REG_STRENGTH: cfg_q.strength <= pwdata[15:0];
        REG_WIDTH:    cfg_q.width    <= pwdata[11:0];
        REG_HEIGHT:   cfg_q.height   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_KERNEL:   prdata = {29'd0, cfg_q.kernel};
      REG_SERP:     prdata = {31'd0, cfg_q.serp};
      REG_BITS:     prdata = {28'd0, cfg_q.bits};
      REG_STRENGTH: prdata = {16'd0, cfg_q.strength};
      REG_WIDTH:    prdata = {20'd0, cfg_q.width};
      REG_HEIGHT:   prdata = {20'd0, cfg_q.height};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/edd_ctrl.sv =====
// Sequencer: pixel steps, tap loop and error memory clearing sweeps.
module edd_ctrl import edd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_SUM, S_STR,
    S_TAP0, S_TAP1, S_TAP2, S_TAP3, S_TAP4, S_DONE
  } state_e;

  state_e               state_q;
  logic [ADDR_W-1:0]    cnt_q;
  logic                 all_q;
  logic [TAP_IDX_W-1:0] idx_q;
  logic                 clr_last;

  assign s_tready = (state_q == S_IDLE);
  assign clr_last = all_q ? (cnt_q == ADDR_W'(MEM_DEPTH - 1))
                          : (cnt_q == ADDR_W'(MAX_WIDTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      all_q   <= 1'b1;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (clr_last) state_q <= S_IDLE;
        end
        S_IDLE: if (s_tvalid) state_q <= S_READ;
        S_READ: state_q <= S_SUM;
        S_SUM:  state_q <= S_STR;
        S_STR: begin
          idx_q   <= '0;
          state_q <= S_TAP0;
        end
        S_TAP0: begin
          if (sts_i.tap_ok) begin
            state_q <= S_TAP1;
          end else if (sts_i.tap_last) begin
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_TAP1: state_q <= S_TAP2;
        S_TAP2: state_q <= S_TAP3;
        S_TAP3: state_q <= S_TAP4;
        S_TAP4: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= sts_i.tap_last ? S_DONE : S_TAP0;
        end
        S_DONE: begin
          if (sts_i.out_free) begin
            cnt_q <= '0;
            all_q <= sts_i.frame_end;
            state_q <= (sts_i.row_end || sts_i.frame_end) ? S_CLEAR : S_IDLE;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.clr_cnt = cnt_q;
    cmd_o.clr_all = all_q;
    cmd_o.tap_idx = idx_q;
    unique case (state_q)
      S_CLEAR: cmd_o.clr_we  = 1'b1;
      S_IDLE:  cmd_o.load    = s_tvalid;
      S_READ:  cmd_o.rd_cur  = 1'b1;
      S_SUM:   cmd_o.sum     = 1'b1;
      S_STR:   cmd_o.mul_str = 1'b1;
      S_TAP0:  cmd_o.tap_a   = sts_i.tap_ok;
      S_TAP1:  cmd_o.tap_b   = 1'b1;
      S_TAP2:  cmd_o.tap_c   = 1'b1;
      S_TAP3:  cmd_o.tap_d   = 1'b1;
      S_TAP4:  cmd_o.wr_tap  = 1'b1;
      S_DONE:  cmd_o.push    = sts_i.out_free;
      default: ;
    endcase
  end

  a_push_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> sts_i.out_free)
    else $error("result pushed into occupied output register");
  a_write_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.clr_we || cmd_o.wr_tap) |-> !(cmd_o.clr_we && cmd_o.wr_tap) && !cmd_o.load)
    else $error("error memory write collides with another access");
  a_clear_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push && sts_i.row_end) |=> (state_q == S_CLEAR && cnt_q == '0))
    else $error("row end not followed by clearing sweep");
  a_tap_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.rd_cur ##1 cmd_o.sum ##1 cmd_o.mul_str)
    else $error("pixel sequence out of order");

endmodule

// ===== hdl/edd_datapath.sv =====
// Quantiser, tap arithmetic, error row memory, position counters and output word.
module edd_datapath import edd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [15:0] s_tdata,
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  output logic        m_tuser
);

  logic [ERR_W-1:0]  mem_q [MEM_DEPTH];
  logic [ERR_W-1:0]  rdata_q;

  logic [COL_W-1:0]  col_q, row_q;
  logic [SLOT_W-1:0] base_q, clr_slot_q;
  logic signed [15:0] pix_q;
  logic signed [23:0] scaled_q;
  logic [7:0]         lvl_q;
  logic signed [16:0] resid_q;
  logic signed [M_W-1:0] m_q;
  logic signed [N_W-1:0] n_q;
  logic [ADDR_W-1:0]  tgt_q;
  logic signed [Q1_W-1:0] q1_q;
  logic [19:0]        r1_q;
  logic [U_W-1:0]     u_q;
  logic [P_W-1:0]     p_q;
  logic signed [ERR_W-1:0] add_q;
  logic               ovalid_q, olast_q, ouser_q;
  logic [7:0]         odata_q;

  logic [11:0]        w12, h12;
  logic [COL_W-1:0]   wm1, hm1, x, cur_col, cur_row;
  logic [3:0]         bits;
  logic [7:0]         levels;
  logic [15:0]        strength;
  logic               rev;
  logic [2:0]         kern;
  logic [4:0]         ksh, cval;
  div_e               kdiv;
  tap_t               tap;
  logic [5:0]         tidx;
  logic signed [13:0] nx;
  logic [2:0]         slot;
  logic [ADDR_W-1:0]  addr;
  logic signed [28:0] sum;
  logic signed [13:0] qr;
  logic               up;

  assign kern = cfg_i.kernel;
  assign ksh  = KERN_SHIFT[kern];
  assign kdiv = KERN_DIV[kern];
  assign cval = div_const(kdiv);

  always_comb begin
    w12 = (cfg_i.width == 12'd0) ? 12'd1 :
          (cfg_i.width > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : cfg_i.width;
    h12 = (cfg_i.height == 12'd0) ? 12'd1 :
          (cfg_i.height > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : cfg_i.height;
    wm1 = COL_W'(w12 - 12'd1);
    hm1 = COL_W'(h12 - 12'd1);
    bits = (cfg_i.bits == 4'd0) ? 4'd1 : (cfg_i.bits > 4'd8) ? 4'd8 : cfg_i.bits;
    levels = 8'((9'd1 << bits) - 9'd1);
    strength = (cfg_i.strength > 16'd32768) ? 16'd32768 : cfg_i.strength;
    cur_col = (col_q > wm1) ? wm1 : col_q;
    cur_row = (row_q > hm1) ? hm1 : row_q;
    rev = cfg_i.serp & row_q[0];
    x = rev ? (wm1 - col_q) : col_q;
  end

  // Tap lookup and frame bounds
  always_comb begin
    logic signed [2:0] dxe;
    tidx = KERN_FIRST[kern] + 6'(cmd_i.tap_idx);
    tap  = (cmd_i.tap_idx < KERN_COUNT[kern]) ? TAP_TABLE[tidx] : TAP_TABLE[0];
    dxe  = rev ? -tap.dx : tap.dx;
    nx   = $signed({3'b000, x}) + 14'(dxe);
    slot = {1'b0, base_q} + {1'b0, tap.dy};
    if (slot >= 3'(ROW_SLOTS)) slot = slot - 3'(ROW_SLOTS);
    sts_o.tap_ok = (cmd_i.tap_idx < KERN_COUNT[kern]) && !nx[13]
                   && (nx[12:0] <= {2'b00, wm1})
                   && ({1'b0, row_q} + {10'd0, tap.dy} <= {1'b0, hm1});
    sts_o.tap_last  = (cmd_i.tap_idx == KERN_COUNT[kern] - 1'b1);
    sts_o.row_end   = (col_q == wm1);
    sts_o.frame_end = (col_q == wm1) && (row_q == hm1);
    sts_o.out_free  = !ovalid_q || m_tready;
  end

  // Quantiser: round half to even at the unit level step
  always_comb begin
    sum = $signed({{1{scaled_q[23]}}, scaled_q, FRAC_UP'(0)}) +
          29'($signed(rdata_q));
    up  = (sum[15:0] > 16'h8000) || (sum[15:0] == 16'h8000 && sum[16]);
    qr  = $signed({sum[28], sum[28:16]}) + $signed({13'd0, up});
  end

  // Error memory, single port with registered read
  always_comb begin
    if (cmd_i.clr_we) begin
      addr = cmd_i.clr_all ? cmd_i.clr_cnt : {clr_slot_q, cmd_i.clr_cnt[COL_W-1:0]};
    end else if (cmd_i.rd_cur) begin
      addr = {base_q, x};
    end else begin
      addr = tgt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [ERR_W:0] v;
    v = $signed({rdata_q[ERR_W-1], rdata_q}) + (ERR_W+1)'(add_q);
    if (cmd_i.clr_we) begin
      mem_q[addr] <= '0;
    end else if (cmd_i.wr_tap) begin
      if (v > $signed((ERR_W+1)'(2**(ERR_W-1) - 1)))   mem_q[addr] <= {1'b0, {(ERR_W-1){1'b1}}};
      else if (v < -$signed((ERR_W+1)'(2**(ERR_W-1)))) mem_q[addr] <= {1'b1, {(ERR_W-1){1'b0}}};
      else                                              mem_q[addr] <= v[ERR_W-1:0];
    end
    if (cmd_i.rd_cur || cmd_i.tap_c || cmd_i.tap_d) rdata_q <= mem_q[addr];
  end

  // Arithmetic pipeline registers
  always_ff @(posedge clk_i) begin
    logic signed [23:0]     q1w;
    logic [U_W:0]           uw;
    logic [21:0]            q0;
    logic [26:0]            qc;
    logic [4:0]             r2;
    logic signed [ERR_W-1:0] q2;
    logic [R_W-1:0]         rr, dd;
    logic                   up2;
    if (cmd_i.load) pix_q <= $signed(s_tdata);
    if (cmd_i.rd_cur) scaled_q <= pix_q * $signed({1'b0, levels});
    if (cmd_i.sum) begin
      lvl_q   <= qr[13] ? 8'd0 : (qr > $signed({6'd0, levels})) ? levels : qr[7:0];
      resid_q <= up ? $signed({1'b0, sum[15:0]} - 17'd65536) : $signed({1'b0, sum[15:0]});
    end
    if (cmd_i.mul_str) m_q <= M_W'(resid_q * $signed({1'b0, strength}));
    if (cmd_i.tap_a) begin
      n_q   <= N_W'(m_q * $signed({1'b0, tap.num}));
      tgt_q <= {slot[SLOT_W-1:0], nx[COL_W-1:0]};
    end
    if (cmd_i.tap_b) begin
      q1w  = 24'(n_q >>> ksh);
      q1_q <= q1w[Q1_W-1:0];
      r1_q <= n_q[19:0] & 20'((21'd1 << ksh) - 21'd1);
      uw   = (U_W+1)'(q1w + $signed({cval, BIAS_SH'(0)}));
      u_q  <= uw[U_W-1:0];
    end
    if (cmd_i.tap_c) p_q <= u_q * div_recip(kdiv);
    if (cmd_i.tap_d) begin
      q0 = p_q[P_W-1:RECIP_SH];
      qc = 27'(q0 * cval);
      if (qc > 27'(u_q)) begin
        q0 = q0 - 1'b1;
        qc = qc - 27'(cval);
      end
      r2 = 5'(27'(u_q) - qc);
      if (kdiv == DIV_1) begin
        q2 = ERR_W'(q1_q);
        rr = R_W'(r1_q);
      end else begin
        q2 = ERR_W'($signed({2'b00, q0}) - $signed(24'(2**BIAS_SH)));
        rr = (R_W'(r2) << ksh) | R_W'(r1_q);
      end
      dd  = R_W'(cval) << ksh;
      up2 = ({rr, 1'b0} > {1'b0, dd}) || ({rr, 1'b0} == {1'b0, dd} && q2[0]);
      add_q <= q2 + $signed({{(ERR_W-1){1'b0}}, up2});
    end
  end

  // Position, ring base and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      base_q     <= '0;
      clr_slot_q <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      if (cmd_i.push) ovalid_q <= 1'b1;
      else if (m_tready) ovalid_q <= 1'b0;
      if (cmd_i.load) begin
        col_q <= cur_col;
        row_q <= cur_row;
      end
      if (cmd_i.push) begin
        if (sts_o.frame_end) begin
          col_q  <= '0;
          row_q  <= '0;
          base_q <= '0;
        end else if (sts_o.row_end) begin
          clr_slot_q <= base_q;
          base_q <= (base_q == SLOT_W'(ROW_SLOTS - 1)) ? '0 : base_q + 1'b1;
          col_q  <= '0;
          row_q  <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      odata_q <= lvl_q;
      olast_q <= sts_o.row_end;
      ouser_q <= sts_o.frame_end;
    end
  end

  assign m_tvalid = ovalid_q;
  assign m_tdata  = odata_q;
  assign m_tlast  = olast_q;
  assign m_tuser  = ouser_q;

endmodule

// ===== hdl/error_diffusion_dither_core.sv =====
// Top level of the single-channel error-diffusion dither core.
// Input words on the s_ side carry one signed Q4.12 sample per pixel in scan
// order (right to left on odd rows when serpentine scan is set). Each word
// yields one output word on the m_ side: the level code in tdata, tlast on
// the last pixel of a row and tuser on the last pixel of the frame.
// A pixel runs through the read, sum and strength steps and then the tap
// loop, in which each kernel tap inside the frame goes through the multiply,
// divide, round and write steps and each tap outside it is skipped; the shared
// tap unit and the single port of the error row memory set the time it takes.
// After the last pixel of a row its error row is swept to zero; after the
// last pixel of a frame all three rows are swept, and the same full sweep
// runs after reset. No input is taken during a sweep.
// A result waits in the output register while the receiver stalls; the next
// pixel is still taken and worked on, and it holds at completion until that
// register is free. Registers are to be written over the APB port only
// while idle; the block does not enforce this. pready is always high.
module error_diffusion_dither_core import edd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] pixel_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] level
  output logic        m_tlast,
  output logic        m_tuser,   // [0] frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  edd_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  edd_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .sts_i(sts), .cmd_o(cmd)
  );

  edd_datapath u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg), .cmd_i(cmd), .sts_o(sts), .s_tdata,
    .m_tready, .m_tvalid, .m_tdata, .m_tlast, .m_tuser
  );

endmodule

// ===== sim/error_diffusion_dither_core_tb.sv =====
// Self-checking testbench of the error-diffusion dither core, with its own level predictor.
`timescale 1ns / 100ps

module error_diffusion_dither_core_tb;
  import edd_pkg::*;

  localparam int ITEMS_PER_PHASE = 45;
  localparam int NUM_PHASES      = 14;
  localparam int SWEEP_WAIT      = 6400;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct {
    logic [7:0] level;
    logic       row_end;
    logic       frame_end;
  } pix_result_t;

  // Kernel taps, laid out kernel after kernel
  localparam int TAP_DX [61] = '{1,-1,0,1,
    1,2,-2,-1,0,1,2,-2,-1,0,1,2,
    1,2,-2,-1,0,1,2,-2,-1,0,1,2,
    1,2,-1,0,1,0,
    1,2,-2,-1,0,1,2,
    1,2,-2,-1,0,1,2,-1,0,1,
    1,2,-2,-1,0,1,2,
    1,-1,0};
  localparam int TAP_DY [61] = '{0,1,1,1,
    0,0,1,1,1,1,1,2,2,2,2,2,
    0,0,1,1,1,1,1,2,2,2,2,2,
    0,0,1,1,1,2,
    0,0,1,1,1,1,1,
    0,0,1,1,1,1,1,2,2,2,
    0,0,1,1,1,1,1,
    0,1,1};
  localparam int TAP_NUM [61] = '{7,3,5,1,
    7,5,3,5,7,5,3,1,3,5,3,1,
    8,4,2,4,8,4,2,1,2,4,2,1,
    1,1,1,1,1,1,
    8,4,2,4,8,4,2,
    5,3,2,4,5,4,2,2,3,2,
    4,3,1,2,3,2,1,
    2,1,1};
  localparam int K_FIRST [8] = '{0, 4, 16, 28, 34, 41, 51, 58};
  localparam int K_COUNT [8] = '{4, 12, 12, 6, 7, 10, 7, 3};
  localparam int K_DEN   [8] = '{16, 48, 42, 8, 32, 32, 16, 4};

  // Directed samples; expected level -1 means the predictor decides
  localparam int DIR_N = 18;
  localparam int DIR_PIX [DIR_N] = '{4096, 32767, -32768, 0, 2048, 1, -1, 16, 4095, 8,
                                     2056, 3000, 100, -4096, 4096, 1234, 16384, 2049};
  localparam int DIR_LVL [DIR_N] = '{255, 255, 0, 0, -1, -1, -1, -1, -1, -1,
                                     -1, -1, -1, -1, -1, -1, -1, -1};

  logic        clk_i, rst_ni;
  logic        s_tvalid, s_tready;
  logic [15:0] s_tdata;   // [15:0] pixel_value
  logic        m_tvalid, m_tready;
  logic [7:0]  m_tdata;   // [7:0] level
  logic        m_tlast;
  logic        m_tuser;   // [0] frame_end
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  error_diffusion_dither_core u_dut (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor state
  logic [2:0]  cfg_kernel;
  logic        cfg_serp;
  logic [3:0]  cfg_bits;
  logic [15:0] cfg_strength;
  logic [11:0] cfg_width, cfg_height;
  int          err_mem [MEM_DEPTH];
  int          col_pos, row_pos, ring_slot;

  pix_result_t expected_levels[$];
  int          typed_levels[$];
  int          errors;
  int          idle_cycles;
  bit          hold_req;
  bit          quiet_sender;

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  function automatic longint round_div(longint n, longint d);
    longint q, r;
    q = n / d;
    r = n % d;
    if (r < 0) begin
      q -= 1;
      r += d;
    end
    if (2 * r > d || (2 * r == d && q[0])) q += 1;
    return q;
  endfunction

  function automatic void clear_errors();
    foreach (err_mem[i]) err_mem[i] = 0;
  endfunction

  function automatic pix_result_t dither_pixel(logic signed [15:0] pix);
    pix_result_t res;
    int     bits, w, h, x, k, nx, dy, tgt;
    longint levels, strength, sum, q, resid, add, v;
    bit     reverse;
    bits = (cfg_bits < 1) ? 1 : (cfg_bits > 8 ? 8 : cfg_bits);
    levels = (64'sd1 << bits) - 1;
    strength = (cfg_strength > 32768) ? 32768 : cfg_strength;
    w = (cfg_width < 1) ? 1 : (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
    h = (cfg_height < 1) ? 1 : (cfg_height > MAX_HEIGHT ? MAX_HEIGHT : cfg_height);
    if (col_pos >= w) col_pos = w - 1;
    if (row_pos >= h) row_pos = h - 1;
    reverse = cfg_serp && row_pos[0];
    x = reverse ? (w - 1 - col_pos) : col_pos;
    sum = longint'(pix) * levels * 16 + err_mem[ring_slot * MAX_WIDTH + x];
    q = round_div(sum, 65536);
    resid = sum - q * 65536;
    res.level = (q < 0) ? 8'd0 : (q > levels ? levels[7:0] : q[7:0]);
    k = cfg_kernel;
    for (int t = K_FIRST[k]; t < K_FIRST[k] + K_COUNT[k]; t++) begin
      nx = x + (reverse ? -TAP_DX[t] : TAP_DX[t]);
      dy = TAP_DY[t];
      if (nx < 0 || nx >= w || dy >= ROW_SLOTS || row_pos + dy >= h) continue;
      add = round_div(resid * strength * TAP_NUM[t], 64'sd32768 * K_DEN[k]);
      tgt = ((ring_slot + dy) % ROW_SLOTS) * MAX_WIDTH + nx;
      v = err_mem[tgt] + add;
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      err_mem[tgt] = int'(v);
    end
    res.row_end = (col_pos == w - 1);
    res.frame_end = res.row_end && (row_pos == h - 1);
    if (res.frame_end) begin
      clear_errors();
      col_pos = 0;
      row_pos = 0;
      ring_slot = 0;
    end else if (res.row_end) begin
      for (int i = 0; i < MAX_WIDTH; i++) err_mem[ring_slot * MAX_WIDTH + i] = 0;
      ring_slot = (ring_slot + 1) % ROW_SLOTS;
      col_pos = 0;
      row_pos += 1;
    end else begin
      col_pos += 1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KERNEL:   cfg_kernel   = val[2:0];
      REG_SERP:     cfg_serp     = val[0];
      REG_BITS:     cfg_bits     = val[3:0];
      REG_STRENGTH: cfg_strength = val[15:0];
      REG_WIDTH:    cfg_width    = val[11:0];
      REG_HEIGHT:   cfg_height   = val[11:0];
      default: ;
    endcase
  endtask

  task automatic send_word(logic [15:0] pix);
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (expected_levels.size() != 0) @(negedge clk_i);
    repeat (SWEEP_WAIT) @(negedge clk_i);
  endtask

  // Monitor: predict on every accepted input, check every accepted output
  always @(posedge clk_i) begin
    pix_result_t want, pred;
    int typed;
    bit busy;
    if (rst_ni) begin
      busy = psel;
      if (s_tvalid && s_tready) begin
        busy = 1'b1;
        pred = dither_pixel(s_tdata);
        if (typed_levels.size() != 0) begin
          typed = typed_levels.pop_front();
          if (typed >= 0) pred.level = typed[7:0];
        end
        expected_levels.push_back(pred);
      end
      if (m_tvalid && m_tready) begin
        busy = 1'b1;
        if (expected_levels.size() == 0) begin
          report_mismatch("unexpected word, level", m_tdata, -1);
        end else begin
          want = expected_levels.pop_front();
          if (m_tdata !== want.level) report_mismatch("level", m_tdata, want.level);
          if (m_tlast !== want.row_end) report_mismatch("row_end", m_tlast, want.row_end);
          if (m_tuser !== want.frame_end)
            report_mismatch("frame_end", m_tuser, want.frame_end);
        end
      end
      idle_cycles <= busy ? 0 : idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: own stall pattern, plus one long hold-off on request
  initial begin
    int hold_cnt, cyc;
    bit stall_mode;
    hold_cnt = 0;
    cyc = 0;
    stall_mode = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 600 == 0) stall_mode = ~stall_mode;
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (quiet_sender) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) != 0);
      end
    end
  end

  initial begin
    int burst, gap, widths, heights;
    logic [15:0] pix;
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    quiet_sender = 1'b0;
    cfg_kernel = 3'd0;
    cfg_serp = 1'b0;
    cfg_bits = 4'd8;
    cfg_strength = 16'd32768;
    cfg_width = 12'd640;
    cfg_height = 12'd480;
    clear_errors();
    col_pos = 0;
    row_pos = 0;
    ring_slot = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed samples at reset settings
    for (int i = 0; i < DIR_N; i++) begin
      typed_levels.push_back(DIR_LVL[i]);
      send_word(16'(DIR_PIX[i]));
    end
    s_tvalid <= 1'b0;
    drain();

    for (int p = 1; p <= NUM_PHASES; p++) begin
      widths  = (p == 5) ? 0 : (p == 7) ? 2048 : (p == 9) ? 4095 : $urandom_range(1, 9);
      heights = (p == 3) ? 0 : (p == 8) ? 4095 : $urandom_range(1, 5);
      write_reg(REG_KERNEL, (p <= 8) ? p - 1 : $urandom_range(0, 7));
      write_reg(REG_SERP, (p <= 8) ? p % 2 : $urandom_range(0, 1));
      write_reg(REG_BITS, (p == 2) ? 0 : (p == 4) ? 15 : (p == 6) ? 1 : (p == 10) ? 8
                          : $urandom_range(1, 9));
      write_reg(REG_STRENGTH, (p == 2) ? 0 : (p == 4) ? 65535 : (p == 6) ? 32768
                              : $urandom_range(0, 40000));
      write_reg(REG_WIDTH, widths);
      write_reg(REG_HEIGHT, heights);
      quiet_sender = (p == 11);
      if (p == 10) hold_req = 1'b1;
      burst = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 20);
          gap = (quiet_sender || p == 10) ? 0 : $urandom_range(0, 6);
          if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk_i);
          end
        end
        burst--;
        // Mostly in-range samples, some anywhere in the field
        pix = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
        send_word(pix);
      end
      s_tvalid <= 1'b0;
      quiet_sender = 1'b0;
      drain();
    end

    while (expected_levels.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
